@@ rtl/rlmd_pkg.sv @@
// Shared constants, register codes and stage control type for the local maximum detector.
package rlmd_pkg;

    localparam int DEF_MAX_COLS    = 2048;
    localparam int DEF_HEIGHT_BITS = 16;

    localparam int MINH_W     = 16;   // min_height register
    localparam int ROWS_W     = 16;   // raster_rows register
    localparam int COLS_REG_W = 12;   // raster_cols register
    localparam int ID_W       = 32;   // point_id / id_base
    localparam int CIDX_W     = 27;   // cell_index
    localparam int ROW_W      = ROWS_W + 1;  // position row runs up to rows + 1

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int OQ_DEPTH   = 4;
    localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);
    localparam int OQ_W       = ID_W + CIDX_W;
    localparam int OUT_W      = ((OQ_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_HEIGHT  = 2'd0,
        REG_RASTER_ROWS = 2'd1,
        REG_RASTER_COLS = 2'd2,
        REG_ID_BASE     = 2'd3
    } t_cfg_reg;

    // Control that travels with an item from the address stage to the window stage
    typedef struct packed {
        logic              fire;      // a center pixel is decided by this item
        logic              above_ok;  // row above the center lies inside the raster
        logic              below_ok;
        logic              left_ok;
        logic              right_ok;
        logic              restart;   // last item of the raster
        logic [CIDX_W-1:0] cidx;
    } t_s1_ctrl;

endpackage

@@ rtl/rlmd_line_mem.sv @@
// Two stacked line buffers in one memory word, read-modify-write with forwarding.
module rlmd_line_mem #(
    parameter int DEPTH = 2048,
    parameter int PIX_W = 17
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [PIX_W-1:0]         i_wr_pix,
    output logic [PIX_W-1:0]         o_up,
    output logic [PIX_W-1:0]         o_mid
);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WORD_W = 2 * PIX_W;

    // word layout: upper line in the high half, middle line in the low half
    logic [WORD_W-1:0] mem [DEPTH];

    logic [WORD_W-1:0] r_rd_word;
    logic [WORD_W-1:0] r_fwd_word;
    logic              r_fwd;
    logic              r_wr_en;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] wr_word;

    assign rd_word = r_fwd ? r_fwd_word : r_rd_word;
    // shift the column down one line: middle moves to upper, new pixel to middle
    assign wr_word = {rd_word[PIX_W-1:0], i_wr_pix};
    assign o_up    = rd_word[WORD_W-1:PIX_W];
    assign o_mid   = rd_word[PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_wr_en) begin
            mem[r_wr_addr] <= wr_word;
        end
        if (i_rd_en) begin
            r_rd_word <= mem[i_addr];
            r_wr_addr <= i_addr;
        end
        r_fwd_word <= wr_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_en <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            r_wr_en <= i_rd_en;
            // same column written while read: take the word being written
            r_fwd   <= i_rd_en && r_wr_en && (r_wr_addr == i_addr);
        end
    end

endmodule

@@ rtl/rlmd_window.sv @@
// Window columns, neighbor comparisons and point identifier counter.
module rlmd_window #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_restart,
    input  logic [rlmd_pkg::ID_W-1:0]       i_id_base,
    input  logic [rlmd_pkg::MINH_W-1:0]     i_min_height,
    input  logic                            i_s1_valid,
    input  rlmd_pkg::t_s1_ctrl              i_s1_ctrl,
    input  logic [HEIGHT_BITS:0]            i_pix,
    input  logic [HEIGHT_BITS:0]            i_up,
    input  logic [HEIGHT_BITS:0]            i_mid,
    output logic                            o_push,
    output logic [rlmd_pkg::ID_W-1:0]       o_point_id,
    output logic [rlmd_pkg::CIDX_W-1:0]     o_cell_index
);
    import rlmd_pkg::*;

    localparam int PIX_W = HEIGHT_BITS + 1;
    localparam int CW    = (HEIGHT_BITS > MINH_W) ? HEIGHT_BITS : MINH_W;

    // rows 0 = upper line, 1 = middle (center row), 2 = newest line
    logic [PIX_W-1:0] r_wl [3];
    logic [PIX_W-1:0] r_wc [3];
    logic [ID_W-1:0]  r_next_id;

    logic [PIX_W-1:0]     ctr;
    logic signed [CW-1:0] ctr_x;
    logic signed [CW-1:0] min_x;
    logic                 blocked;
    logic                 fire;

    function automatic logic nb_gt(input logic [PIX_W-1:0] n, input logic [PIX_W-1:0] c);
        return n[PIX_W-1] && ($signed(n[PIX_W-2:0]) > $signed(c[PIX_W-2:0]));
    endfunction

    function automatic logic nb_ge(input logic [PIX_W-1:0] n, input logic [PIX_W-1:0] c);
        return n[PIX_W-1] && ($signed(n[PIX_W-2:0]) >= $signed(c[PIX_W-2:0]));
    endfunction

    assign ctr   = r_wc[1];
    assign ctr_x = CW'($signed(ctr[PIX_W-2:0]));
    assign min_x = CW'($signed(i_min_height));

    always_comb begin
        blocked =
            (i_s1_ctrl.below_ok && nb_gt(r_wc[2], ctr)) ||
            (i_s1_ctrl.right_ok && nb_gt(i_mid, ctr)) ||
            (i_s1_ctrl.right_ok && i_s1_ctrl.below_ok && nb_gt(i_pix, ctr)) ||
            (i_s1_ctrl.right_ok && i_s1_ctrl.above_ok && nb_gt(i_up, ctr)) ||
            (i_s1_ctrl.above_ok && nb_ge(r_wc[0], ctr)) ||
            (i_s1_ctrl.left_ok && nb_ge(r_wl[1], ctr)) ||
            (i_s1_ctrl.left_ok && i_s1_ctrl.above_ok && nb_ge(r_wl[0], ctr)) ||
            (i_s1_ctrl.left_ok && i_s1_ctrl.below_ok && nb_ge(r_wl[2], ctr));
        fire = i_s1_valid && i_s1_ctrl.fire && ctr[PIX_W-1] && (ctr_x >= min_x) && !blocked;
    end

    assign o_push       = fire;
    assign o_point_id   = r_next_id;
    assign o_cell_index = i_s1_ctrl.cidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_wl[i] <= '0;
                r_wc[i] <= '0;
            end
            r_next_id <= '0;
        end else if (i_cfg_restart) begin
            for (int i = 0; i < 3; i++) begin
                r_wl[i] <= '0;
                r_wc[i] <= '0;
            end
            r_next_id <= i_id_base;
        end else if (i_s1_valid) begin
            if (i_s1_ctrl.restart) begin
                // end of raster: drop the whole window
                for (int i = 0; i < 3; i++) begin
                    r_wl[i] <= '0;
                    r_wc[i] <= '0;
                end
                r_next_id <= i_id_base;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    r_wl[i] <= r_wc[i];
                end
                r_wc[0] <= i_up;
                r_wc[1] <= i_mid;
                r_wc[2] <= i_pix;
                if (fire) begin
                    r_next_id <= r_next_id + ID_W'(1);
                end
            end
        end
    end

endmodule

@@ rtl/rlmd_out_fifo.sv @@
// Small output queue that decouples the result stream from the pixel pipeline.
module rlmd_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [rlmd_pkg::ID_W-1:0]     i_point_id,
    input  logic [rlmd_pkg::CIDX_W-1:0]   i_cell_index,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [rlmd_pkg::OUT_W-1:0]    o_tdata,
    output logic [rlmd_pkg::OQ_CNT_W-1:0] o_count
);
    import rlmd_pkg::*;

    logic [OQ_W-1:0]     r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wp;
    logic [OQ_PTR_W-1:0] r_rp;
    logic [OQ_CNT_W-1:0] r_cnt;
    logic                pop;

    assign o_tvalid = (r_cnt != '0);
    assign o_tdata  = OUT_W'(r_mem[r_rp]);
    assign o_count  = r_cnt;
    assign pop      = o_tvalid && i_tready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= {i_cell_index, i_point_id};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + OQ_PTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + OQ_PTR_W'(1);
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + OQ_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - OQ_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/raster_local_max_detect_unit.sv @@
// Top level of the 3x3 local maximum detector over a streamed height raster.
//
// Usage: pixels enter on the s_axis channel in row-major order; tuser carries the
// item kind (0 pixel, 1 flush step), tdata the height and its data-valid bit. Each
// high point leaves on m_axis as {cell_index, point_id}. Registers are written over
// the cfg channel (index 0 min_height, 1 raster_rows, 2 raster_cols, 3 id_base);
// the user must write them only while the block is idle, the block does not
// enforce it. Writing rows, cols or id_base restarts the raster. Throughput: one
// item per cycle while s_axis_tready is high. A pixel is decided raster_cols + 1
// items after it entered, so raster_cols + 1 flush items drain the last row; the
// item that decides the last pixel also restarts position, window and identifier.
// Each item is registered into the compare stage, whose window compare pushes a
// result into the queue. Each column is written in the cycle after its read, and
// a write and a read of the same column forward the written word.
// Stall: results wait in a four-entry queue; s_axis_tready drops only when the
// queue and the compare stage together could fill it.
// Reset: registers return to their defaults, position zero, window empty, the
// identifier counter loads id_base; the line memory is not cleared, since rows
// before the raster start are never looked at.
module raster_local_max_detect_unit #(
    parameter int MAX_COLS    = rlmd_pkg::DEF_MAX_COLS,
    parameter int HEIGHT_BITS = rlmd_pkg::DEF_HEIGHT_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // fields from bit 0: height, pixel_valid, zero fill
    input  logic [((HEIGHT_BITS+8)/8)*8-1:0]  i_s_axis_tdata,
    // fields from bit 0: mode
    input  logic                              i_s_axis_tuser,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // fields from bit 0: point_id, cell_index, zero fill
    output logic [rlmd_pkg::OUT_W-1:0]        o_m_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rlmd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rlmd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rlmd_pkg::*;

    localparam int PIX_W = HEIGHT_BITS + 1;
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ECW   = $clog2(MAX_COLS + 1);
    localparam int EW    = (ECW > COLS_REG_W) ? ECW : COLS_REG_W;

    // configuration
    logic [MINH_W-1:0] r_min_height;
    logic [ROWS_W-1:0] r_rows_eff;
    logic [ECW-1:0]    r_cols_eff;
    logic [ID_W-1:0]   r_id_base;
    logic              r_cfg_restart;

    // position of the next item
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [CIDX_W-1:0] r_lin;

    // compare stage
    logic              r_s1_v;
    t_s1_ctrl          r_s1_ctrl;
    logic [PIX_W-1:0]  r_s1_pix;

    logic              cfg_we;
    logic              cfg_restart;
    logic [EW-1:0]     cfg_cols;
    logic [ECW-1:0]    cfg_cols_eff;
    logic [ROWS_W-1:0] cfg_rows_eff;

    logic              acc;
    logic              take;
    logic              in_mode;
    logic              in_valid;
    logic [HEIGHT_BITS-1:0] in_h;
    logic [ROW_W-1:0]  rows_x;
    logic              flush;
    logic              at_c0;
    logic              end_step;
    logic              wrap;
    logic              pv;
    t_s1_ctrl          n_ctrl;

    logic [PIX_W-1:0]  up;
    logic [PIX_W-1:0]  mid;
    logic              push;
    logic [ID_W-1:0]   push_id;
    logic [CIDX_W-1:0] push_cidx;
    logic [OQ_CNT_W-1:0] oq_count;
    logic [OQ_CNT_W:0]   occ;

    // configuration port
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign cfg_restart = cfg_we && (t_cfg_reg'(i_cfg_index) != REG_MIN_HEIGHT);
    assign cfg_cols    = EW'(i_cfg_data[COLS_REG_W-1:0]);

    always_comb begin
        if (cfg_cols == '0) begin
            cfg_cols_eff = ECW'(1);
        end else if (cfg_cols > EW'(MAX_COLS)) begin
            cfg_cols_eff = ECW'(MAX_COLS);
        end else begin
            cfg_cols_eff = ECW'(cfg_cols);
        end
        if (i_cfg_data[ROWS_W-1:0] == '0) begin
            cfg_rows_eff = ROWS_W'(1);
        end else begin
            cfg_rows_eff = i_cfg_data[ROWS_W-1:0];
        end
    end

    // input side
    assign occ             = {1'b0, oq_count} + (OQ_CNT_W+1)'(r_s1_v);
    assign o_s_axis_tready = occ < (OQ_CNT_W+1)'(OQ_DEPTH);
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;
    assign in_mode         = i_s_axis_tuser;
    assign in_h            = i_s_axis_tdata[HEIGHT_BITS-1:0];
    assign in_valid        = i_s_axis_tdata[HEIGHT_BITS];

    assign rows_x   = {1'b0, r_rows_eff};
    assign at_c0    = (r_col == '0);
    assign flush    = in_mode || (r_row >= rows_x);
    // a flush step before any pixel changes nothing
    assign take     = acc && !(in_mode && (r_row == '0) && at_c0);
    assign pv       = !flush && in_valid;
    assign end_step = at_c0 && (r_row == rows_x + ROW_W'(1));
    assign wrap     = (ECW'(r_col) + ECW'(1)) >= r_cols_eff;

    always_comb begin
        n_ctrl.restart = end_step;
        n_ctrl.cidx    = r_lin - CIDX_W'(r_cols_eff) - CIDX_W'(1);
        if (at_c0) begin
            // center is the last column of the row two back
            n_ctrl.fire     = r_row >= ROW_W'(2);
            n_ctrl.above_ok = r_row >= ROW_W'(3);
            n_ctrl.below_ok = r_row <= rows_x;
            n_ctrl.left_ok  = r_cols_eff >= ECW'(2);
            n_ctrl.right_ok = 1'b0;
        end else begin
            n_ctrl.fire     = (r_row >= ROW_W'(1)) && (r_row <= rows_x);
            n_ctrl.above_ok = r_row >= ROW_W'(2);
            n_ctrl.below_ok = r_row < rows_x;
            n_ctrl.left_ok  = r_col >= COL_W'(2);
            n_ctrl.right_ok = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_ctrl <= n_ctrl;
            r_s1_pix  <= {pv, in_h};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_height  <= '0;
            r_rows_eff    <= ROWS_W'(1);
            r_cols_eff    <= ECW'(1);
            r_id_base     <= '0;
            r_cfg_restart <= 1'b0;
            r_row         <= '0;
            r_col         <= '0;
            r_lin         <= '0;
            r_s1_v        <= 1'b0;
        end else begin
            r_cfg_restart <= cfg_restart;
            r_s1_v        <= take;
            if (cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_MIN_HEIGHT:  r_min_height <= i_cfg_data[MINH_W-1:0];
                    REG_RASTER_ROWS: r_rows_eff   <= cfg_rows_eff;
                    REG_RASTER_COLS: r_cols_eff   <= cfg_cols_eff;
                    REG_ID_BASE:     r_id_base    <= i_cfg_data[ID_W-1:0];
                    default:         r_min_height <= r_min_height;
                endcase
            end
            if (cfg_restart) begin
                r_row <= '0;
                r_col <= '0;
                r_lin <= '0;
            end else if (take) begin
                if (end_step) begin
                    r_row <= '0;
                    r_col <= '0;
                    r_lin <= '0;
                end else begin
                    r_lin <= r_lin + CIDX_W'(1);
                    if (wrap) begin
                        r_col <= '0;
                        r_row <= r_row + ROW_W'(1);
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end
            end
        end
    end

    rlmd_line_mem #(
        .DEPTH (MAX_COLS),
        .PIX_W (PIX_W)
    ) u_line_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (take),
        .i_addr   (r_col),
        .i_wr_pix (r_s1_pix),
        .o_up     (up),
        .o_mid    (mid)
    );

    rlmd_window #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_restart (r_cfg_restart),
        .i_id_base     (r_id_base),
        .i_min_height  (r_min_height),
        .i_s1_valid    (r_s1_v),
        .i_s1_ctrl     (r_s1_ctrl),
        .i_pix         (r_s1_pix),
        .i_up          (up),
        .i_mid         (mid),
        .o_push        (push),
        .o_point_id    (push_id),
        .o_cell_index  (push_cidx)
    );

    rlmd_out_fifo u_out_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_point_id   (push_id),
        .i_cell_index (push_cidx),
        .o_tvalid     (o_m_axis_tvalid),
        .i_tready     (i_m_axis_tready),
        .o_tdata      (o_m_axis_tdata),
        .o_count      (oq_count)
    );

endmodule

@@ tb/tb_raster_local_max_detect_unit.sv @@
// Self-checking testbench for the 3x3 raster local maximum detector.
module tb_raster_local_max_detect_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rlmd_pkg::*;

    localparam int MAX_COLS       = DEF_MAX_COLS;
    localparam int S_W            = ((DEF_HEIGHT_BITS + 8) / 8) * 8;
    localparam int RAND_ITEMS     = 1250;
    localparam int WIDE_ITEMS     = 64;
    localparam int DRAIN_CYCLES   = 8;
    localparam int END_CYCLES     = 20;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    localparam logic [3:0] SEL_MINH = 4'b1 << REG_MIN_HEIGHT;
    localparam logic [3:0] SEL_ROWS = 4'b1 << REG_RASTER_ROWS;
    localparam logic [3:0] SEL_COLS = 4'b1 << REG_RASTER_COLS;
    localparam logic [3:0] SEL_BASE = 4'b1 << REG_ID_BASE;
    localparam logic [3:0] SEL_ALL  = SEL_MINH | SEL_ROWS | SEL_COLS | SEL_BASE;

    typedef struct packed {
        logic               ok;
        logic signed [15:0] z;
    } cell_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [CIDX_W-1:0] cidx;
    } peak_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [S_W-1:0]        i_s_axis_tdata = '0;    // height, pixel_valid, zero fill
    logic                  i_s_axis_tuser = 1'b0;  // mode
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [OUT_W-1:0]      o_m_axis_tdata;         // point_id, cell_index, zero fill
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    raster_local_max_detect_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Detector state as seen from outside
    logic signed [15:0] cfg_minh;
    logic [15:0]        cfg_rows;
    logic [11:0]        cfg_cols;
    logic [31:0]        cfg_base;
    cell_t              line_up  [MAX_COLS];
    cell_t              line_mid [MAX_COLS];
    cell_t              win [3][3];
    int                 pos_row;
    int                 pos_col;
    logic [31:0]        id_next;

    peak_t pending_points[$];
    int    fail_count   = 0;
    int    items_sent   = 0;
    bit    calm         = 1'b0;
    int    hold_reqs    = 0;
    int    hold_seen    = 0;
    int    hold_left    = 0;
    int    stall_left   = 0;
    int    idle_cycles  = 0;

    function automatic int rows_eff();
        return (cfg_rows == 0) ? 1 : int'(cfg_rows);
    endfunction

    function automatic int cols_eff();
        int c;
        c = (cfg_cols == 0) ? 1 : int'(cfg_cols);
        return (c > MAX_COLS) ? MAX_COLS : c;
    endfunction

    function automatic void restart_detector();
        int i, j;
        pos_row = 0;
        pos_col = 0;
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
                win[i][j] = '0;
        id_next = cfg_base;
    endfunction

    function automatic void reset_detector();
        int i;
        cfg_minh = '0;
        cfg_rows = 16'd1;
        cfg_cols = 12'd1;
        cfg_base = '0;
        for (i = 0; i < MAX_COLS; i++) begin
            line_up[i]  = '0;
            line_mid[i] = '0;
        end
        restart_detector();
    endfunction

    function automatic void apply_reg(t_cfg_reg idx, logic [31:0] val);
        case (idx)
            REG_MIN_HEIGHT: cfg_minh = val[15:0];
            REG_RASTER_ROWS: begin
                cfg_rows = val[15:0];
                restart_detector();
            end
            REG_RASTER_COLS: begin
                cfg_cols = val[11:0];
                restart_detector();
            end
            REG_ID_BASE: begin
                cfg_base = val;
                restart_detector();
            end
            default: ;
        endcase
    endfunction

    // Neighbor at (dr,dc) of the center in window column k; outside or no-data never blocks
    function automatic bit blocks_center(int cr, int cc, int k, int dr, int dc, bit tie_ok);
        int    r, c, wc;
        cell_t nb, ctr;
        r  = cr + dr;
        c  = cc + dc;
        wc = k + dc;
        if (r < 0 || c < 0 || r >= rows_eff() || c >= cols_eff() || wc < 0 || wc > 2)
            return 1'b0;
        nb  = win[1 + dr][wc];
        ctr = win[1][k];
        if (!nb.ok)
            return 1'b0;
        return tie_ok ? ($signed(nb.z) > $signed(ctr.z)) : ($signed(nb.z) >= $signed(ctr.z));
    endfunction

    function automatic void judge_center(int cr, int cc, int k);
        cell_t           ctr;
        peak_t           pk;
        longint unsigned flat;
        ctr = win[1][k];
        if (!ctr.ok || $signed(ctr.z) < $signed(cfg_minh))
            return;
        // ties allowed below and to the right, strictly lower required above and to the left
        if (blocks_center(cr, cc, k, 1, 0, 1'b1) || blocks_center(cr, cc, k, 0, 1, 1'b1) ||
            blocks_center(cr, cc, k, 1, 1, 1'b1) || blocks_center(cr, cc, k, -1, 1, 1'b1) ||
            blocks_center(cr, cc, k, -1, 0, 1'b0) || blocks_center(cr, cc, k, 0, -1, 1'b0) ||
            blocks_center(cr, cc, k, -1, -1, 1'b0) || blocks_center(cr, cc, k, 1, -1, 1'b0))
            return;
        flat    = longint'(cr) * longint'(cols_eff()) + longint'(cc);
        pk.id   = id_next;
        pk.cidx = flat[CIDX_W-1:0];
        pending_points.insert(pending_points.size(), pk);
        id_next = id_next + 32'd1;
    endfunction

    function automatic void advance_detector(logic mode, logic [15:0] h, logic v);
        int    rows, cols, r, c, i;
        logic  drain;
        cell_t px, mid, up;
        rows = rows_eff();
        cols = cols_eff();
        r    = pos_row;
        c    = pos_col;
        if (mode == MODE_FLUSH && r == 0 && c == 0)
            return;
        drain = (mode == MODE_FLUSH) || r >= rows;
        if (c >= cols)
            c = cols - 1;
        px.ok = !drain && v;
        px.z  = px.ok ? h : '0;
        if (c == 0 && r >= 2)
            judge_center(r - 2, cols - 1, 2);
        mid = line_mid[c];
        up  = line_up[c];
        for (i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2]   = up;
        win[1][2]   = mid;
        win[2][2]   = px;
        line_up[c]  = mid;
        line_mid[c] = px;
        if (c >= 1 && r >= 1 && r - 1 < rows)
            judge_center(r - 1, c - 1, 1);
        if (c == 0 && r == rows + 1) begin
            restart_detector();
            return;
        end
        c++;
        if (c >= cols) begin
            c = 0;
            r++;
        end
        pos_row = r;
        pos_col = c;
    endfunction

    function automatic logic [15:0] pick_height(int base, int spread);
        if ($urandom_range(0, 15) == 0)
            return 16'($urandom);
        return 16'(base + int'($urandom_range(0, spread)));
    endfunction

    task automatic send_item(input logic mode, input logic [15:0] h, input logic v);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= mode;
        i_s_axis_tdata  <= S_W'({v, h});
        @(posedge i_clk);
        while (o_s_axis_tready !== 1'b1)
            @(posedge i_clk);
        advance_detector(mode, h, v);
        items_sent++;
    endtask

    // Stop sending and wait until the pipeline is empty
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1)
            @(posedge i_clk);
        apply_reg(idx, val);
    endtask

    task automatic load_regs(input logic [3:0] sel, input logic [31:0] minh,
                             input logic [31:0] rows, input logic [31:0] cols,
                             input logic [31:0] base);
        settle();
        if (sel[REG_MIN_HEIGHT])  write_reg(REG_MIN_HEIGHT, minh);
        if (sel[REG_RASTER_ROWS]) write_reg(REG_RASTER_ROWS, rows);
        if (sel[REG_RASTER_COLS]) write_reg(REG_RASTER_COLS, cols);
        if (sel[REG_ID_BASE])     write_reg(REG_ID_BASE, base);
        i_cfg_valid <= 1'b0;
    endtask

    // One raster with random content and its drain, sometimes cut short
    task automatic rand_raster(output bit cut_short);
        int total, npix, cut, base, spread, n;
        npix   = rows_eff() * cols_eff();
        total  = npix + cols_eff() + 1;
        cut    = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, total - 1)) : total;
        base   = int'($urandom_range(0, 80)) - 40;
        spread = $urandom_range(1, 4);
        for (n = 0; n < cut; n++) begin
            if (n < npix) begin
                if (n > 0 && $urandom_range(0, 19) == 0)
                    send_item(MODE_FLUSH, 16'($urandom), 1'($urandom));
                else
                    send_item(MODE_PIXEL, pick_height(base, spread), $urandom_range(0, 9) != 0);
            end else if ($urandom_range(0, 4) == 0) begin
                send_item(MODE_PIXEL, 16'($urandom), 1'($urandom));
            end else begin
                send_item(MODE_FLUSH, 16'($urandom), 1'($urandom));
            end
            // change the threshold mid-raster; it applies without a restart
            if ($urandom_range(0, 199) == 0)
                load_regs(SEL_MINH, 32'(base + int'($urandom_range(0, spread))), 0, 0, 0);
        end
        cut_short = (cut < total);
    endtask

    task automatic random_rasters(input int n_items);
        int          start_items;
        bit          cut_short;
        logic [3:0]  sel;
        logic [31:0] minh, rows, cols, base;
        start_items = items_sent;
        cut_short   = 1'b0;
        while (items_sent < start_items + n_items) begin
            sel = 4'($urandom_range(0, 15));
            if (cut_short)
                sel = sel | SEL_ROWS;
            case ($urandom_range(0, 9))
                0: minh = 32'h0000_8000;
                1: minh = 32'h0000_7FFF;
                2: minh = $urandom;
                default: minh = 32'(int'($urandom_range(0, 80)) - 40);
            endcase
            rows = ($urandom_range(0, 15) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
            case ($urandom_range(0, 15))
                0: cols = 32'd0;
                1: cols = 32'($urandom_range(13, 40));
                default: cols = 32'($urandom_range(1, 10));
            endcase
            base = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : $urandom;
            if (sel != 0)
                load_regs(sel, minh, rows, cols, base);
            rand_raster(cut_short);
        end
    endtask

    // Defaults after reset: one-by-one raster, idle flush, pixel past the raster
    task automatic test_reset_defaults();
        send_item(MODE_FLUSH, 16'h1234, 1'b1);
        send_item(MODE_PIXEL, 16'd5, 1'b1);
        send_item(MODE_FLUSH, '0, 1'b0);
        send_item(MODE_FLUSH, '0, 1'b0);
        send_item(MODE_PIXEL, 16'd0, 1'b1);
        send_item(MODE_PIXEL, 16'hFFFF, 1'b1);
        send_item(MODE_FLUSH, '0, 1'b0);
    endtask

    // Height extremes, ties, no-data and flush inside the raster, identifier wrap
    task automatic test_edges_3x3();
        load_regs(SEL_ALL, 32'hFFFF_8000, 3, 3, 32'hFFFF_FFFF);
        send_item(MODE_PIXEL, 16'h7FFF, 1'b1);
        send_item(MODE_PIXEL, 16'h7FFF, 1'b1);
        send_item(MODE_PIXEL, 16'h8000, 1'b1);
        send_item(MODE_PIXEL, 16'h8000, 1'b1);
        send_item(MODE_FLUSH, 16'h7FFF, 1'b1);
        send_item(MODE_PIXEL, 16'h7FFF, 1'b1);
        send_item(MODE_PIXEL, 16'hFFFF, 1'b0);
        send_item(MODE_PIXEL, 16'h7FFF, 1'b1);
        send_item(MODE_PIXEL, 16'h8000, 1'b1);
        send_item(MODE_PIXEL, 16'h7FFF, 1'b1);
        send_item(MODE_FLUSH, '0, 1'b0);
        send_item(MODE_FLUSH, '0, 1'b0);
        send_item(MODE_FLUSH, '0, 1'b0);
    endtask

    // Zero rows and columns act as one; highest threshold
    task automatic test_zero_dims();
        load_regs(SEL_MINH | SEL_ROWS | SEL_COLS, 32'h0000_7FFF, 0, 0, 0);
        send_item(MODE_PIXEL, 16'h7FFF, 1'b1);
        send_item(MODE_FLUSH, '0, 1'b0);
        send_item(MODE_FLUSH, '0, 1'b0);
    endtask

    // Tallest raster with a column count above the line buffer, cut short by the next test
    task automatic test_wide_rows();
        int n;
        load_regs(SEL_ALL, 32'hFFFF_FFF0, 65535, 4095, $urandom);
        for (n = 0; n < WIDE_ITEMS; n++)
            send_item(MODE_PIXEL, pick_height(-12, 3), $urandom_range(0, 9) != 0);
    endtask

    // Hold the output for a long stretch so the result queue fills and input stalls
    task automatic test_output_stall();
        int r, c;
        load_regs(SEL_ALL, 32'hFFFF_8000, 4, 8, 32'd100);
        hold_reqs++;
        for (r = 0; r < 4; r++)
            for (c = 0; c < 8; c++)
                send_item(MODE_PIXEL, (r % 2 == 0 && c % 2 == 0) ? 16'd10 : 16'd0, 1'b1);
        for (c = 0; c <= 8; c++)
            send_item(MODE_FLUSH, '0, 1'b0);
        settle();
    endtask

    task automatic test_random();
        random_rasters(RAND_ITEMS);
    endtask

    task automatic test_no_idling();
        calm = 1'b1;
        random_rasters(150);
    endtask

    initial begin
        reset_detector();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_edges_3x3();
        test_zero_dims();
        test_wide_rows();
        test_output_stall();
        test_random();
        test_no_idling();
        settle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result sink: random stalls plus requested long holds
    always @(posedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        peak_t             want;
        logic [ID_W-1:0]   got_id;
        logic [CIDX_W-1:0] got_cidx;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            got_id   = o_m_axis_tdata[ID_W-1:0];
            got_cidx = o_m_axis_tdata[ID_W +: CIDX_W];
            if (pending_points.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected high point: id %08h cell %0d", got_id, got_cidx);
            end else begin
                want = pending_points.pop_front();
                if (got_id !== want.id) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("point_id mismatch: expected %08h, got %08h", want.id, got_id);
                end
                if (got_cidx !== want.cidx) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("cell_index mismatch (id %08h): expected %0d, got %0d",
                                 want.id, want.cidx, got_cidx);
                end
            end
        end
    end

    // Abort when no channel moves an item for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready === 1'b1) ||
            (o_m_axis_tvalid === 1'b1 && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
